FILE: rtl/atipd_pkg.sv
`timescale 1ns / 1ps

package atipd_pkg;

  // Store sizes and length field width
  localparam int LINE_DEPTH   = 128;
  localparam int PACKET_DEPTH = 128;
  localparam int LENGTH_BITS  = 16;

  // Derived widths
  localparam int LINE_AW    = $clog2(LINE_DEPTH);
  localparam int LINE_CNT_W = $clog2(LINE_DEPTH + 1);
  localparam int PKT_AW     = $clog2(PACKET_DEPTH);
  localparam int PKT_CNT_W  = $clog2(PACKET_DEPTH + 1);

  // Fixed field widths
  localparam int FUNC_W  = 2;
  localparam int BYTE_W  = 8;
  localparam int IDX_W   = 7;
  localparam int KIND_W  = 2;
  localparam int COUNT_W = 8;

  // Ending detector: last seven received bytes
  localparam int TAIL_W = 56;
  localparam logic [31:0] PAT_OK    = 32'h4F4B_0D0A;             // "OK\r\n"
  localparam logic [55:0] PAT_ERROR = 56'h45_5252_4F52_0D0A;     // "ERROR\r\n"
  localparam logic [39:0] PAT_IPD   = 40'h2B_4950_442C;          // "+IPD,"

  localparam logic [7:0] CHAR_COLON = 8'h3A;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  // Transaction function codes
  localparam logic [FUNC_W-1:0] FUNC_RX        = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_RD_REPLY  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_RD_PACKET = 2'd2;

  // Result kinds
  localparam logic [KIND_W-1:0] KIND_OK     = 2'd0;
  localparam logic [KIND_W-1:0] KIND_ERROR  = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PACKET = 2'd2;
  localparam logic [KIND_W-1:0] KIND_READ   = 2'd3;

  // Parser mode
  typedef enum logic [1:0] {
    MODE_LINE    = 2'd0,
    MODE_LENGTH  = 2'd1,
    MODE_PAYLOAD = 2'd2
  } mode_e;

endpackage

FILE: rtl/at_reply_and_ipd_frame_parser.sv
`timescale 1ns / 1ps

// Channel | handshake            | payload
// --------+----------------------+----------------------------------------------
// in      | in_valid_i/in_ready_o| func_i, rx_byte_i, read_index_i
// out     | out_valid_o/out_ready_i | kind_o, count_o, data_o, in_range_o,
//         |                      | truncated_o
//
// One transaction per cycle while in_ready_o is high; a result, if any, is
// registered and shows in the next cycle (store reads use a synchronous port).
// A completed reply swaps the two banks of the line memory, so no copy runs.
// Reset clears the parser control state only; the memories are not cleared.
// in_ready_o drops only while a result is held and out_ready_i is low.
module at_reply_and_ipd_frame_parser (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [atipd_pkg::FUNC_W-1:0]  func_i,
  input  logic [atipd_pkg::BYTE_W-1:0]  rx_byte_i,
  input  logic [atipd_pkg::IDX_W-1:0]   read_index_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [atipd_pkg::KIND_W-1:0]  kind_o,
  output logic [atipd_pkg::COUNT_W-1:0] count_o,
  output logic [atipd_pkg::BYTE_W-1:0]  data_o,
  output logic                          in_range_o,
  output logic                          truncated_o
);
  import atipd_pkg::*;

  localparam int LCMP_W = (LINE_CNT_W > IDX_W) ? LINE_CNT_W : IDX_W;
  localparam int PIDX_W = (PKT_CNT_W > IDX_W) ? PKT_CNT_W : IDX_W;
  localparam int PCMP_W = (PKT_CNT_W > LENGTH_BITS) ? PKT_CNT_W : LENGTH_BITS;
  localparam int MUL_W  = LENGTH_BITS + 4;

  // Memories: line store in two banks (line / saved reply), packet store
  logic [BYTE_W-1:0] line_mem_q [2*LINE_DEPTH];
  logic [BYTE_W-1:0] pkt_mem_q  [PACKET_DEPTH];

  // Control state
  mode_e                  mode_q, mode_d;
  logic [LINE_CNT_W-1:0]  line_cnt_q, line_cnt_d;
  logic                   line_ovf_q, line_ovf_d;
  logic [TAIL_W-1:0]      tail_q, tail_d;
  logic                   bank_q, bank_d;
  logic [LENGTH_BITS-1:0] decl_len_q, decl_len_d;
  logic [LENGTH_BITS-1:0] pay_cnt_q, pay_cnt_d;
  logic [LINE_CNT_W-1:0]  reply_len_q, reply_len_d;
  logic                   reply_trunc_q, reply_trunc_d;
  logic [PKT_CNT_W-1:0]   pkt_len_q, pkt_len_d;
  logic                   pkt_trunc_q, pkt_trunc_d;

  // Output stage
  logic                   out_valid_q, out_valid_d;
  logic [KIND_W-1:0]      kind_q;
  logic [COUNT_W-1:0]     count_q;
  logic                   in_range_q;
  logic                   trunc_q;
  logic                   sel_pkt_q;
  logic [BYTE_W-1:0]      line_rd_q;
  logic [BYTE_W-1:0]      pkt_rd_q;

  // Per-transaction results
  logic                   accept;
  logic                   res_valid;
  logic [KIND_W-1:0]      res_kind;
  logic [COUNT_W-1:0]     res_count;
  logic                   res_in_range;
  logic                   res_trunc;
  logic                   res_sel_pkt;

  // Memory port controls
  logic                   line_we, line_re;
  logic [LINE_AW:0]       line_waddr, line_raddr;
  logic                   pkt_we, pkt_re;
  logic [PKT_AW-1:0]      pkt_waddr, pkt_raddr;

  // Scratch values
  logic [TAIL_W-1:0]      tail_new;
  logic [LINE_CNT_W-1:0]  line_cnt_new;
  logic                   line_ovf_new;
  logic [MUL_W-1:0]       len_mul;
  logic [LENGTH_BITS-1:0] pay_next;
  logic                   finish;
  logic                   fin_trunc;
  logic                   rd_ok;

  assign in_ready_o = !out_valid_q || out_ready_i;
  assign accept     = in_valid_i && in_ready_o;

  // Parser next state, result and memory controls
  always_comb begin
    mode_d        = mode_q;
    line_cnt_d    = line_cnt_q;
    line_ovf_d    = line_ovf_q;
    tail_d        = tail_q;
    bank_d        = bank_q;
    decl_len_d    = decl_len_q;
    pay_cnt_d     = pay_cnt_q;
    reply_len_d   = reply_len_q;
    reply_trunc_d = reply_trunc_q;
    pkt_len_d     = pkt_len_q;
    pkt_trunc_d   = pkt_trunc_q;

    res_valid    = 1'b0;
    res_kind     = KIND_READ;
    res_count    = '0;
    res_in_range = 1'b0;
    res_trunc    = 1'b0;
    res_sel_pkt  = 1'b0;

    line_we    = 1'b0;
    line_re    = 1'b0;
    line_waddr = {bank_q, line_cnt_q[LINE_AW-1:0]};
    line_raddr = {!bank_q, LINE_AW'(read_index_i)};
    pkt_we     = 1'b0;
    pkt_re     = 1'b0;
    pkt_waddr  = PKT_AW'(pay_cnt_q);
    pkt_raddr  = PKT_AW'(read_index_i);

    tail_new     = {tail_q[TAIL_W-9:0], rx_byte_i};
    line_cnt_new = line_cnt_q;
    line_ovf_new = line_ovf_q;
    len_mul      = MUL_W'({decl_len_q, 3'b000}) + MUL_W'({decl_len_q, 1'b0})
                 + MUL_W'(rx_byte_i - CHAR_ZERO);
    pay_next     = pay_cnt_q + 1'b1;
    finish       = 1'b0;
    fin_trunc    = PCMP_W'(decl_len_q) > PCMP_W'(PACKET_DEPTH);
    rd_ok        = 1'b0;

    if (accept) begin
      case (func_i)
        FUNC_RX: begin
          case (mode_q)
            MODE_LENGTH: begin
              if (rx_byte_i == CHAR_COLON) begin
                if (decl_len_q == '0) begin
                  finish = 1'b1;
                end else begin
                  mode_d    = MODE_PAYLOAD;
                  pay_cnt_d = '0;
                end
              end else if (rx_byte_i inside {[CHAR_ZERO:CHAR_NINE]}) begin
                // saturate once ten times the length plus the digit overflows
                if (len_mul > MUL_W'({LENGTH_BITS{1'b1}})) begin
                  decl_len_d = '1;
                end else begin
                  decl_len_d = len_mul[LENGTH_BITS-1:0];
                end
              end
            end
            MODE_PAYLOAD: begin
              if (PCMP_W'(pay_cnt_q) < PCMP_W'(PACKET_DEPTH)) begin
                pkt_we = 1'b1;
              end
              pay_cnt_d = pay_next;
              if (pay_next >= decl_len_q) begin
                finish = 1'b1;
              end
            end
            default: begin
              // line mode
              if (line_cnt_q < LINE_CNT_W'(LINE_DEPTH)) begin
                line_we      = 1'b1;
                line_cnt_new = line_cnt_q + 1'b1;
              end else begin
                line_ovf_new = 1'b1;
              end
              line_cnt_d = line_cnt_new;
              line_ovf_d = line_ovf_new;
              tail_d     = tail_new;
              if (tail_new[31:0] == PAT_OK || tail_new == PAT_ERROR) begin
                // reply done: the line bank becomes the reply bank
                res_valid     = 1'b1;
                res_kind      = (tail_new[31:0] == PAT_OK) ? KIND_OK : KIND_ERROR;
                res_count     = COUNT_W'(line_cnt_new);
                res_trunc     = line_ovf_new;
                reply_len_d   = line_cnt_new;
                reply_trunc_d = line_ovf_new;
                bank_d        = !bank_q;
                line_cnt_d    = '0;
                line_ovf_d    = 1'b0;
                tail_d        = '0;
              end else if (tail_new[39:0] == PAT_IPD) begin
                line_cnt_d = '0;
                line_ovf_d = 1'b0;
                tail_d     = '0;
                mode_d     = MODE_LENGTH;
                decl_len_d = '0;
                pay_cnt_d  = '0;
              end
            end
          endcase

          if (finish) begin
            res_valid   = 1'b1;
            res_kind    = KIND_PACKET;
            pkt_trunc_d = fin_trunc;
            pkt_len_d   = fin_trunc ? PKT_CNT_W'(PACKET_DEPTH) : PKT_CNT_W'(decl_len_q);
            res_count   = COUNT_W'(pkt_len_d);
            res_trunc   = fin_trunc;
            mode_d      = MODE_LINE;
            decl_len_d  = '0;
            pay_cnt_d   = '0;
          end
        end
        FUNC_RD_REPLY: begin
          rd_ok = (LCMP_W'(read_index_i) < LCMP_W'(reply_len_q))
               && (LCMP_W'(read_index_i) < LCMP_W'(LINE_DEPTH));
          line_re      = rd_ok;
          res_valid    = 1'b1;
          res_count    = COUNT_W'(reply_len_q);
          res_in_range = rd_ok;
          res_trunc    = reply_trunc_q;
        end
        FUNC_RD_PACKET: begin
          rd_ok = (PIDX_W'(read_index_i) < PIDX_W'(pkt_len_q))
               && (PIDX_W'(read_index_i) < PIDX_W'(PACKET_DEPTH));
          pkt_re       = rd_ok;
          res_valid    = 1'b1;
          res_count    = COUNT_W'(pkt_len_q);
          res_in_range = rd_ok;
          res_trunc    = pkt_trunc_q;
          res_sel_pkt  = 1'b1;
        end
        default: begin
          // unused function code: no result
        end
      endcase
    end
  end

  // Output valid: load on accept, drop when taken
  always_comb begin
    if (accept) begin
      out_valid_d = res_valid;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q        <= MODE_LINE;
      line_cnt_q    <= '0;
      line_ovf_q    <= 1'b0;
      tail_q        <= '0;
      bank_q        <= 1'b0;
      decl_len_q    <= '0;
      pay_cnt_q     <= '0;
      reply_len_q   <= '0;
      reply_trunc_q <= 1'b0;
      pkt_len_q     <= '0;
      pkt_trunc_q   <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      mode_q        <= mode_d;
      line_cnt_q    <= line_cnt_d;
      line_ovf_q    <= line_ovf_d;
      tail_q        <= tail_d;
      bank_q        <= bank_d;
      decl_len_q    <= decl_len_d;
      pay_cnt_q     <= pay_cnt_d;
      reply_len_q   <= reply_len_d;
      reply_trunc_q <= reply_trunc_d;
      pkt_len_q     <= pkt_len_d;
      pkt_trunc_q   <= pkt_trunc_d;
      out_valid_q   <= out_valid_d;
    end
  end

  // Result payload register
  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q     <= res_kind;
      count_q    <= res_count;
      in_range_q <= res_in_range;
      trunc_q    <= res_trunc;
      sel_pkt_q  <= res_sel_pkt;
    end
  end

  // Line memory: one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (line_we) begin
      line_mem_q[line_waddr] <= rx_byte_i;
    end
    if (line_re) begin
      line_rd_q <= line_mem_q[line_raddr];
    end
  end

  // Packet memory: one write or one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (pkt_we) begin
      pkt_mem_q[pkt_waddr] <= rx_byte_i;
    end
    if (pkt_re) begin
      pkt_rd_q <= pkt_mem_q[pkt_raddr];
    end
  end

  assign out_valid_o = out_valid_q;
  assign kind_o      = kind_q;
  assign count_o     = count_q;
  assign in_range_o  = in_range_q;
  assign truncated_o = trunc_q;
  assign data_o      = !in_range_q ? '0 : (sel_pkt_q ? pkt_rd_q : line_rd_q);

`ifndef SYNTHESIS
  // payload mode always has a nonzero length still to fill
  a_payload_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mode_q == MODE_PAYLOAD |-> (decl_len_q != '0) && (pay_cnt_q < decl_len_q))
    else $error("payload count out of bounds");

  // overflow only once the line store is full
  a_line_ovf: assert property (@(posedge clk_i) disable iff (!rst_ni)
    line_ovf_q |-> line_cnt_q == LINE_CNT_W'(LINE_DEPTH))
    else $error("line overflow with free space");

  // every read transaction gives a read result next cycle
  a_read_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (func_i == FUNC_RD_REPLY || func_i == FUNC_RD_PACKET)
    |=> out_valid_o && kind_o == KIND_READ)
    else $error("read transaction without read result");

  // a reply completion swaps the banks and restarts the line
  a_bank_swap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && res_valid && (res_kind == KIND_OK || res_kind == KIND_ERROR)
    |=> bank_q != $past(bank_q) && line_cnt_q == '0)
    else $error("reply completion without bank swap");
`endif

endmodule
